### rtl/core/bslp_pkg.sv
// Shared constants and types for the short/long press detector.
package bslp_pkg;

  // Number of keys scanned per sample
  localparam int NUM_KEYS = 3;

  // Width of the key index carried on the result channel
  localparam int KEY_W = 2;

  // Hold limit in ms after reset
  localparam logic [15:0] LIMIT_RESET = 16'd1000;

  // Samples that can sit between classifier and event sequencer
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Event codes
  localparam logic EVT_SHORT = 1'b0;
  localparam logic EVT_LONG  = 1'b1;

  // Classified events of one sample: which keys fired, and the kind for each
  typedef struct packed {
    logic [NUM_KEYS-1:0] hit;
    logic [NUM_KEYS-1:0] kind;
  } event_set_t;

  // Queue status seen by the two sides
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

### rtl/core/bslp_front.sv
// Sample classifier: per-key press tracking and event detection.
module bslp_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [15:0]                 cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  key_levels,
  input  logic [31:0]                 now_time,
  input  bslp_pkg::queue_status_t     q_status,
  output logic                        q_push,
  output bslp_pkg::event_set_t        q_data
);
  import bslp_pkg::*;

  logic [15:0]         long_press_limit;
  logic [NUM_KEYS-1:0] was_pressed;
  logic [31:0]         press_start [NUM_KEYS];
  logic [NUM_KEYS-1:0] long_fired;

  logic [NUM_KEYS-1:0] down;
  logic [NUM_KEYS-1:0] rise;
  logic [NUM_KEYS-1:0] long_fired_next;
  event_set_t          evs;
  logic                accept;

  // Keys past the input field read as pressed
  always_comb begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (i < 3) down[i] = ~key_levels[i];
      else       down[i] = 1'b1;
    end
  end

  // Per-key classification, one lane per key
  always_comb begin
    logic [31:0] elapsed;
    logic        below;
    for (int i = 0; i < NUM_KEYS; i++) begin
      elapsed            = now_time - press_start[i];
      below              = elapsed < {16'd0, long_press_limit};
      rise[i]            = down[i] & ~was_pressed[i];
      evs.hit[i]         = 1'b0;
      evs.kind[i]        = EVT_SHORT;
      long_fired_next[i] = long_fired[i];
      if (rise[i]) begin
        long_fired_next[i] = 1'b0;
      end else if (!down[i] && was_pressed[i]) begin
        evs.hit[i] = below & ~long_fired[i];
      end else if (down[i] && !long_fired[i] && !below) begin
        evs.hit[i]         = 1'b1;
        evs.kind[i]        = EVT_LONG;
        long_fired_next[i] = 1'b1;
      end
    end
  end

  assign in_stall = q_status.full;
  assign accept   = in_valid & ~in_stall;
  assign q_push   = accept & (|evs.hit);
  assign q_data   = evs;

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      long_press_limit <= cfg_data;
    end
  end

  // Per-key state update on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      was_pressed <= '0;
      long_fired  <= '0;
      for (int i = 0; i < NUM_KEYS; i++) press_start[i] <= '0;
    end else if (accept) begin
      was_pressed <= down;
      long_fired  <= long_fired_next;
      for (int i = 0; i < NUM_KEYS; i++) begin
        if (rise[i]) press_start[i] <= now_time;
      end
    end
  end

endmodule

### rtl/core/bslp_queue.sv
// Short queue of classified samples between classifier and sequencer.
module bslp_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  bslp_pkg::event_set_t    push_data,
  input  logic                    pop,
  output bslp_pkg::event_set_t    head,
  output bslp_pkg::queue_status_t status
);
  import bslp_pkg::*;

  event_set_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Never overfill or drain an empty queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full && !pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && status.empty))
    else $error("queue pop while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> !status.empty)
    else $error("queue empty after push");

endmodule

### rtl/core/bslp_back.sv
// Event sequencer: emits one event per cycle while the output is not stalled, in key order, marks the last.
module bslp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  bslp_pkg::event_set_t          head,
  input  bslp_pkg::queue_status_t       q_status,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bslp_pkg::KEY_W-1:0]    key_index,
  output logic                          event_kind,
  output logic                          last_event
);
  import bslp_pkg::*;

  event_set_t          rem;
  event_set_t          src;
  logic                rem_busy;
  logic                src_ok;
  logic                advance;
  logic [KEY_W-1:0]    sel_idx;
  logic [NUM_KEYS-1:0] sel_mask;
  logic                sel_kind;
  logic [NUM_KEYS-1:0] rest;

  assign rem_busy = |rem.hit;
  assign src      = rem_busy ? rem : head;
  assign src_ok   = rem_busy | ~q_status.empty;
  assign advance  = ~out_valid | ~out_stall;
  assign q_pop    = advance & ~rem_busy & ~q_status.empty;

  // Lowest pending key wins
  always_comb begin
    sel_idx  = '0;
    sel_mask = '0;
    sel_kind = EVT_SHORT;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (src.hit[i]) begin
        sel_idx  = KEY_W'(i);
        sel_mask = NUM_KEYS'(1) << i;
        sel_kind = src.kind[i];
      end
    end
    rest = src.hit & ~sel_mask;
  end

  // Output register and remaining-event register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rem.hit   <= '0;
    end else if (advance) begin
      if (src_ok) begin
        out_valid <= 1'b1;
        rem.hit   <= rest;
        rem.kind  <= src.kind;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && src_ok) begin
      key_index  <= sel_idx;
      event_kind <= sel_kind;
      last_event <= (rest == '0);
    end
  end

  // A sample's events stay contiguous on the output
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_event) |=> out_valid)
    else $error("gap inside a sample's events");
  a_pending_shown: assert property (@(posedge clk) disable iff (rst)
    rem_busy |-> (out_valid && !last_event))
    else $error("pending events without a shown non-last event");
  a_key_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_event) |=> (key_index > $past(key_index)))
    else $error("events out of key order");

endmodule

### rtl/core/button_short_long_press.sv
// Top level of the short/long press detector.
// Each accepted transaction is one scan sample (active-low key levels and a
// millisecond timestamp). The classifier takes a sample every cycle while its
// two-entry sample queue has room, updates the per-key press state in that
// cycle and queues the sample's events; samples with no events are absorbed.
// The sequencer emits events one per cycle while the output is not stalled,
// in key order from its output register, with last_event set on the final
// event of a sample, so a sample with k events (up to 3) yields k output
// transfers; the first event is registered into the output register straight
// from the queue head. A stall on the output backs up the queue and then the
// input. The limit register may be written only while no sample is in flight.
module button_short_long_press (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [15:0]               cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                key_levels,
  input  logic [31:0]               now_time,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [bslp_pkg::KEY_W-1:0] key_index,
  output logic                      event_kind,
  output logic                      last_event
);
  import bslp_pkg::*;

  queue_status_t q_status;
  event_set_t    q_data;
  event_set_t    q_head;
  logic          q_push;
  logic          q_pop;

  bslp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .key_levels (key_levels),
    .now_time   (now_time),
    .q_status   (q_status),
    .q_push     (q_push),
    .q_data     (q_data)
  );

  bslp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  bslp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_status   (q_status),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .key_index  (key_index),
    .event_kind (event_kind),
    .last_event (last_event)
  );

endmodule

### tb/button_short_long_press_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the short/long press detector, with its own event predictor.
module button_short_long_press_tb;
  import bslp_pkg::*;

  localparam int HOLD_CYCLES = 80;
  localparam int SEG_ITEMS   = 26;
  localparam int NUM_SEGS    = 6;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             kind;
    logic             last;
  } press_evt_t;

  typedef enum logic { ROW_SAMPLE, ROW_LIMIT } row_kind_t;

  // One directed step: a limit write, or a sample with optional hand-typed events
  typedef struct {
    row_kind_t        op;
    logic [15:0]      limit;
    logic [2:0]       levels;
    logic [31:0]      stamp;
    int               n_typed;
    press_evt_t [2:0] evs;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [15:0]         cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [2:0]          key_levels;
  logic [31:0]         now_time;
  logic                out_valid;
  logic                out_stall;
  logic [KEY_W-1:0]    key_index;
  logic                event_kind;
  logic                last_event;

  // Predictor state
  logic [15:0]         hold_limit;
  logic [NUM_KEYS-1:0] key_down_q;
  logic [NUM_KEYS-1:0] long_done;
  logic [31:0]         down_since [NUM_KEYS];

  press_evt_t          pending_evts [$];
  dir_row_t            dir_rows [$];
  int                  errors;
  int unsigned         snd_idle;
  int unsigned         rcv_idle;
  int                  hold_reqs;

  button_short_long_press uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .key_levels (key_levels),
    .now_time   (now_time),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .key_index  (key_index),
    .event_kind (event_kind),
    .last_event (last_event)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic press_evt_t ev(input int key, input logic kind, input logic last);
    press_evt_t e;
    e.key  = KEY_W'(key);
    e.kind = kind;
    e.last = last;
    return e;
  endfunction

  // Walks the keys of one sample in order, updates the press state, returns the events
  function automatic int classify_sample(input logic [2:0] lv, input logic [31:0] t,
                                         output press_evt_t [2:0] evs);
    int          n;
    logic        dn;
    logic        fire;
    logic        kind;
    logic [31:0] held;
    n = 0;
    evs = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      // keys past the field width read as pressed
      dn   = (i < $bits(lv)) ? ~lv[i] : 1'b1;
      held = t - down_since[i];
      fire = 1'b0;
      kind = EVT_SHORT;
      if (dn && !key_down_q[i]) begin
        down_since[i] = t;
        long_done[i]  = 1'b0;
      end else if (!dn && key_down_q[i]) begin
        if (held < {16'd0, hold_limit} && !long_done[i]) begin
          fire = 1'b1;
          kind = EVT_SHORT;
        end
      end else if (dn && !long_done[i]) begin
        if (held >= {16'd0, hold_limit}) begin
          fire = 1'b1;
          kind = EVT_LONG;
          long_done[i] = 1'b1;
        end
      end
      key_down_q[i] = dn;
      if (fire) begin
        evs[n] = ev(i, kind, 1'b0);
        n++;
      end
    end
    if (n > 0) evs[n-1].last = 1'b1;
    return n;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic add_sample(input logic [2:0] lv, input logic [31:0] t, input int n = -1,
                            input press_evt_t e0 = '0, input press_evt_t e1 = '0,
                            input press_evt_t e2 = '0);
    dir_row_t row;
    row.op      = ROW_SAMPLE;
    row.limit   = '0;
    row.levels  = lv;
    row.stamp   = t;
    row.n_typed = n;
    row.evs     = {e2, e1, e0};
    dir_rows.push_back(row);
  endtask

  task automatic add_limit(input logic [15:0] val);
    dir_row_t row;
    row.op      = ROW_LIMIT;
    row.limit   = val;
    row.levels  = '0;
    row.stamp   = '0;
    row.n_typed = 0;
    row.evs     = '0;
    dir_rows.push_back(row);
  endtask

  // Offer one sample, wait for the transaction, then queue its expected events
  task automatic put_sample(input logic [2:0] lv, input logic [31:0] t, input int n_typed,
                            input press_evt_t [2:0] typed);
    press_evt_t [2:0] evs;
    int               n;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    key_levels <= lv;
    now_time   <= t;
    do @(posedge clk); while (in_stall);
    n = classify_sample(lv, t, evs);
    if (n_typed >= 0) begin
      n   = n_typed;
      evs = typed;
    end
    for (int k = 0; k < n; k++) pending_evts.push_back(evs[k]);
  endtask

  // Limit writes happen only with nothing in flight
  task automatic write_limit(input logic [15:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_evts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we     <= 1'b0;
    hold_limit = val;
  endtask

  // Receiver: random stall, plus one long hold-off on request
  initial begin : receiver
    int served;
    served    = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != served) begin
        served = hold_reqs;
        out_stall <= 1'b1;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < rcv_idle);
      end
    end
  end

  // Compare each result transaction with the oldest expected event
  always @(posedge clk) begin : event_check
    press_evt_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_evts.size() == 0) begin
        note_error($sformatf("unexpected event: key %0d kind %0d last %0d",
                             key_index, event_kind, last_event));
      end else begin
        want = pending_evts.pop_front();
        if (key_index !== want.key || event_kind !== want.kind || last_event !== want.last)
          note_error($sformatf("event mismatch: exp key %0d kind %0d last %0d, got %0d %0d %0d",
                               want.key, want.kind, want.last,
                               key_index, event_kind, last_event));
      end
    end
  end

  initial begin : stimulus
    logic [2:0]  lv;
    logic [2:0]  cur_lv;
    logic [2:0]  flip;
    logic [31:0] t;
    logic [31:0] cur_t;
    int unsigned lim;
    int unsigned r;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    key_levels = 3'b111;
    now_time   = '0;
    errors     = 0;
    hold_reqs  = 0;
    snd_idle   = 34;
    rcv_idle   = 84;
    hold_limit = LIMIT_RESET;
    key_down_q = '0;
    long_done  = '0;
    for (int i = 0; i < NUM_KEYS; i++) down_since[i] = '0;

    // Directed: reset limit, all keys long, time wrap, zero and minimum limit, time backwards
    add_sample(3'b111, 32'd0, 0);
    add_sample(3'b110, 32'd100, 0);
    add_sample(3'b111, 32'd1099, 1, ev(0, EVT_SHORT, 1'b1));
    add_sample(3'b000, 32'd2000, 0);
    add_sample(3'b000, 32'd2999, 0);
    add_sample(3'b000, 32'd3000, 3, ev(0, EVT_LONG, 1'b0), ev(1, EVT_LONG, 1'b0),
               ev(2, EVT_LONG, 1'b1));
    add_sample(3'b000, 32'hFFFF_FFFF);
    add_sample(3'b111, 32'hFFFF_FFFF, 0);
    add_limit(16'hFFFF);
    add_sample(3'b101, 32'hFFFF_FF00, 0);
    add_sample(3'b111, 32'h0000_FE00, 1, ev(1, EVT_SHORT, 1'b1));
    add_limit(16'd0);
    add_sample(3'b011, 32'd10, 0);
    add_sample(3'b011, 32'd10, 1, ev(2, EVT_LONG, 1'b1));
    add_sample(3'b111, 32'd11, 0);
    add_sample(3'b110, 32'd20);
    add_sample(3'b111, 32'd20);
    add_limit(16'd1);
    add_sample(3'b100, 32'd100, 0);
    add_sample(3'b111, 32'd100, 2, ev(0, EVT_SHORT, 1'b0), ev(1, EVT_SHORT, 1'b1));
    add_sample(3'b110, 32'd500);
    add_sample(3'b111, 32'd400);
    add_limit(LIMIT_RESET);
    add_sample(3'b010, 32'd0);
    add_sample(3'b000, 32'd1000);
    add_sample(3'b111, 32'd1500);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_LIMIT) write_limit(dir_rows[i].limit);
      else put_sample(dir_rows[i].levels, dir_rows[i].stamp, dir_rows[i].n_typed,
                      dir_rows[i].evs);
    end

    // Random: keys toggle like real presses, time steps scaled to the limit
    cur_lv = 3'b111;
    cur_t  = 32'd1500;
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg)
        0:       lim = 1;
        1:       lim = 65535;
        2:       lim = $urandom_range(2, 300);
        3:       lim = 1000;
        4:       lim = $urandom_range(1, 20);
        default: lim = $urandom_range(1, 65535);
      endcase
      write_limit(lim[15:0]);
      snd_idle = (seg < 2) ? 34 : (seg < 4) ? 84 : 0;
      rcv_idle = (seg < 2) ? 84 : (seg < 4) ? 34 : 0;
      // long output hold-off while the sender keeps offering
      if (seg == 4) hold_reqs <= hold_reqs + 1;
      for (int k = 0; k < SEG_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 10) begin
          lv = 3'($urandom_range(0, 7));
        end else begin
          for (int b = 0; b < 3; b++) flip[b] = ($urandom_range(0, 99) < 30);
          lv = cur_lv ^ flip;
        end
        r = $urandom_range(0, 99);
        if (r < 35)      t = cur_t + $urandom_range(0, lim);
        else if (r < 70) t = cur_t + $urandom_range(lim / 2, 2 * lim);
        else if (r < 85) t = cur_t + lim - 1 + $urandom_range(0, 2);
        else if (r < 93) t = cur_t;
        else             t = $urandom;
        put_sample(lv, t, -1, '0);
        cur_lv = lv;
        cur_t  = t;
      end
    end

    in_valid <= 1'b0;
    while (pending_evts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("button_short_long_press verification clean");
    end else begin
      $display("button_short_long_press verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5_000_000;
    $display("button_short_long_press verification failed");
    $finish;
  end

endmodule
